// ----- rtl/qxm_pkg.sv -----
// Shared constants, codes and control types for the quad X-frame motor mixer.
package qxm_pkg;

  // Default fixed-point fraction width of torques, gains and forces
  localparam int FRAC_BITS_DEF = 16;

  // Field widths
  localparam int TORQUE_W  = 32;
  localparam int FORCE_W   = 32;
  localparam int GAIN_W    = 31;
  localparam int MODE_W    = 2;
  localparam int OFFSET_W  = 11;
  localparam int COMPARE_W = 11;
  localparam int CFG_IDX_W = 2;

  // Packed stream widths (whole bytes)
  localparam int S_DATA_W = 112;
  localparam int M_DATA_W = 48;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIX_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_GAIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOVER_FORCE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_GAIN    = 2'd3;

  // Mixing modes
  localparam logic [MODE_W-1:0] MODE_PITCH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ROLL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FULL  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_HOLD  = 2'd3;

  // Register reset values
  localparam logic [MODE_W-1:0] MIX_MODE_RST    = MODE_FULL;
  localparam logic [GAIN_W-1:0] ARM_GAIN_RST    = 31'd131072;
  localparam logic [GAIN_W-1:0] HOVER_FORCE_RST = 31'd240000;
  localparam logic [GAIN_W-1:0] YAW_GAIN_RST    = 31'd930611;

  // Thrust-to-throttle curve, Q2.30
  localparam int COEF_A_W   = 23;
  localparam int COEF_BC_W  = 28;
  localparam int CURVE_FRAC = 30;
  localparam logic signed [COEF_A_W-1:0]  COEF_A = -23'sd2438897;
  localparam logic signed [COEF_BC_W-1:0] COEF_B = 28'sd104063836;
  localparam logic signed [COEF_BC_W-1:0] COEF_C = 28'sd126368675;

  // Force clamp in newtons, throttle scale and output limits
  localparam int FORCE_LIMIT_N = 64;
  localparam int SCALE_W       = 11;
  localparam logic signed [SCALE_W-1:0] THR_SCALE = 11'sd1000;
  localparam logic signed [COMPARE_W-1:0] THR_MAX = 11'sd750;
  localparam logic signed [COMPARE_W-1:0] THR_MIN = 11'sd100;
  localparam logic [COMPARE_W-1:0] PWM_BASE = 11'd1000;

  // Pipeline stage count, input to output register
  localparam int STAGES = 7;

  // Stage enables of the mixing front end
  typedef struct packed {
    logic s1_en;    // product stage loads
    logic s2_en;    // force stage loads
    logic s2_take;  // force stage loads a valid item
  } mix_ctl_t;

  // Stage enables of the curve back end
  typedef struct packed {
    logic s3_en;
    logic s4_en;
    logic s5_en;
    logic s6_en;
    logic s7_en;
  } curve_ctl_t;

endpackage

// ----- rtl/qxm_mix.sv -----
// Mixing front end: gain products, then per-motor force sums with saturation and hold.
module qxm_mix #(
  parameter int FRAC_BITS = qxm_pkg::FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  qxm_pkg::mix_ctl_t                         ctl,
  input  logic [qxm_pkg::MODE_W-1:0]                mix_mode,
  input  logic [qxm_pkg::GAIN_W-1:0]                arm_gain,
  input  logic [qxm_pkg::GAIN_W-1:0]                yaw_gain,
  input  logic [qxm_pkg::GAIN_W-1:0]                hover_force,
  input  logic signed [qxm_pkg::TORQUE_W-1:0]       roll_torque,
  input  logic signed [qxm_pkg::TORQUE_W-1:0]       pitch_torque,
  input  logic signed [qxm_pkg::TORQUE_W-1:0]       yaw_torque,
  output logic [3:0][qxm_pkg::FORCE_W-1:0]          motor_force
);
  import qxm_pkg::*;

  localparam int PROD_W = 2 * TORQUE_W;
  localparam int TERM_W = PROD_W - FRAC_BITS;
  localparam int SUM_W  = TERM_W + 3;

  logic signed [PROD_W-1:0] r_prod;
  logic signed [PROD_W-1:0] p_prod;
  logic signed [PROD_W-1:0] y_prod;
  logic signed [TERM_W-1:0] r_term;
  logic signed [TERM_W-1:0] p_term;
  logic signed [TERM_W-1:0] y_term;
  logic signed [SUM_W-1:0]  r_ext;
  logic signed [SUM_W-1:0]  p_ext;
  logic signed [SUM_W-1:0]  y_ext;
  logic signed [SUM_W-1:0]  h_ext;
  logic signed [SUM_W-1:0]  sum [4];
  logic [3:0][FORCE_W-1:0]  force_next;
  logic [3:0][FORCE_W-1:0]  held_force;

  // Clip a wide sum to the signed 32-bit range
  function automatic logic [FORCE_W-1:0] sat_force(input logic signed [SUM_W-1:0] v);
    logic ovf;
    ovf = (v[SUM_W-1:FORCE_W-1] != {(SUM_W-FORCE_W+1){v[SUM_W-1]}});
    if (!ovf) begin
      sat_force = v[FORCE_W-1:0];
    end else if (v[SUM_W-1]) begin
      sat_force = {1'b1, {(FORCE_W-1){1'b0}}};
    end else begin
      sat_force = {1'b0, {(FORCE_W-1){1'b1}}};
    end
  endfunction

  // Stage 1: gain times torque
  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      r_prod <= $signed({1'b0, arm_gain}) * roll_torque;
      p_prod <= $signed({1'b0, arm_gain}) * pitch_torque;
      y_prod <= $signed({1'b0, yaw_gain}) * yaw_torque;
    end
  end

  // Scale terms back to the force format, rounding toward minus infinity
  assign r_term = $signed(r_prod[PROD_W-1:FRAC_BITS]);
  assign p_term = $signed(p_prod[PROD_W-1:FRAC_BITS]);
  assign y_term = $signed(y_prod[PROD_W-1:FRAC_BITS]);
  assign r_ext  = SUM_W'(r_term);
  assign p_ext  = SUM_W'(p_term);
  assign y_ext  = SUM_W'(y_term);
  assign h_ext  = $signed({{(SUM_W-GAIN_W){1'b0}}, hover_force});

  // Mix per the selected mode
  always_comb begin
    case (mix_mode)
      MODE_PITCH: begin
        sum[0] = h_ext + p_ext;
        sum[1] = h_ext - p_ext;
        sum[2] = h_ext + p_ext;
        sum[3] = h_ext - p_ext;
      end
      MODE_ROLL: begin
        sum[0] = h_ext - r_ext;
        sum[1] = h_ext - r_ext;
        sum[2] = h_ext + r_ext;
        sum[3] = h_ext + r_ext;
      end
      default: begin
        sum[0] = h_ext - r_ext + p_ext + y_ext;
        sum[1] = h_ext - r_ext - p_ext - y_ext;
        sum[2] = h_ext + r_ext + p_ext - y_ext;
        sum[3] = h_ext + r_ext - p_ext + y_ext;
      end
    endcase
  end

  // Hold mode reuses the last mixed forces
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      force_next[i] = (mix_mode == MODE_HOLD) ? held_force[i] : sat_force(sum[i]);
    end
  end

  // Track the last mixed forces
  always_ff @(posedge clk) begin
    if (rst) begin
      held_force <= '0;
    end else if (ctl.s2_take && mix_mode != MODE_HOLD) begin
      held_force <= force_next;
    end
  end

  // Stage 2: force registers
  always_ff @(posedge clk) begin
    if (ctl.s2_en) begin
      motor_force <= force_next;
    end
  end

endmodule

// ----- rtl/qxm_curve.sv -----
// Per-motor thrust-to-throttle curve, scaling, offset and output saturation.
module qxm_curve #(
  parameter int FRAC_BITS = qxm_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  qxm_pkg::curve_ctl_t                   ctl,
  input  logic [qxm_pkg::FORCE_W-1:0]           motor_force,
  input  logic signed [qxm_pkg::OFFSET_W-1:0]   offset,
  input  logic                                  low_power,
  output logic [qxm_pkg::COMPARE_W-1:0]         compare
);
  import qxm_pkg::*;

  localparam int FC_W   = FRAC_BITS + 8;
  localparam int SQ_W   = 2 * FC_W;
  localparam int T_W    = SQ_W - FRAC_BITS;
  localparam int AT_W   = T_W + COEF_A_W;
  localparam int ATS_W  = AT_W - FRAC_BITS;
  localparam int BF_W   = FC_W + COEF_BC_W;
  localparam int BFS_W  = BF_W - FRAC_BITS;
  localparam int M_W    = ATS_W + 1;
  localparam int MK_W   = M_W + SCALE_W;
  localparam int THR_W  = MK_W - CURVE_FRAC;
  localparam int TO_W   = THR_W + 1;

  localparam logic signed [FORCE_W-1:0] LIM_POS = FORCE_W'(FORCE_LIMIT_N) <<< FRAC_BITS;
  localparam logic signed [FORCE_W-1:0] LIM_NEG = -LIM_POS;
  localparam logic signed [MK_W-1:0]    TRUNC_BIAS = (MK_W'(1) <<< CURVE_FRAC) - MK_W'(1);

  logic signed [FORCE_W-1:0] frc;
  logic signed [FORCE_W-1:0] fc_full;
  logic signed [FC_W-1:0]    fc;
  logic signed [SQ_W-1:0]    sq;
  logic signed [BF_W-1:0]    bf;
  logic signed [T_W-1:0]     t;
  logic signed [AT_W-1:0]    at;
  logic signed [BFS_W-1:0]   bfs;
  logic signed [ATS_W-1:0]   ats;
  logic signed [M_W-1:0]     m;
  logic signed [MK_W-1:0]    mk;
  logic signed [MK_W-1:0]    mk_adj;
  logic signed [THR_W-1:0]   thr;
  logic signed [TO_W-1:0]    thr_off;
  logic signed [TO_W-1:0]    thr_sat;
  logic [COMPARE_W-1:0]      compare_next;

  // Clamp the force to the curve's working range
  assign frc = $signed(motor_force);
  always_comb begin
    if (frc > LIM_POS) begin
      fc_full = LIM_POS;
    end else if (frc < LIM_NEG) begin
      fc_full = LIM_NEG;
    end else begin
      fc_full = frc;
    end
  end
  assign fc = $signed(fc_full[FC_W-1:0]);

  // Stage 3: square and linear products
  always_ff @(posedge clk) begin
    if (ctl.s3_en) begin
      sq <= fc * fc;
      bf <= COEF_B * fc;
    end
  end

  assign t = $signed(sq[SQ_W-1:FRAC_BITS]);

  // Stage 4: quadratic product and scaled linear term
  always_ff @(posedge clk) begin
    if (ctl.s4_en) begin
      at  <= COEF_A * t;
      bfs <= $signed(bf[BF_W-1:FRAC_BITS]);
    end
  end

  assign ats = $signed(at[AT_W-1:FRAC_BITS]);

  // Stage 5: curve value in Q2.30
  always_ff @(posedge clk) begin
    if (ctl.s5_en) begin
      m <= M_W'(ats) + M_W'(bfs) + M_W'(COEF_C);
    end
  end

  // Stage 6: scale to per-mille throttle
  always_ff @(posedge clk) begin
    if (ctl.s6_en) begin
      mk <= m * THR_SCALE;
    end
  end

  // Truncate toward zero, add offset and saturate
  assign mk_adj  = mk + (mk[MK_W-1] ? TRUNC_BIAS : '0);
  assign thr     = $signed(mk_adj[MK_W-1:CURVE_FRAC]);
  assign thr_off = TO_W'(thr) + TO_W'(offset);

  always_comb begin
    if (thr_off > TO_W'(THR_MAX)) begin
      thr_sat = TO_W'(THR_MAX);
    end else if (thr_off < TO_W'(THR_MIN)) begin
      thr_sat = TO_W'(THR_MIN);
    end else begin
      thr_sat = thr_off;
    end
    compare_next = low_power ? PWM_BASE : (thr_sat[COMPARE_W-1:0] + PWM_BASE);
  end

  // Stage 7: output register
  always_ff @(posedge clk) begin
    if (ctl.s7_en) begin
      compare <= compare_next;
    end
  end

endmodule

// ----- rtl/quad_x_motor_mixer_core.sv -----
// Throughput: one transaction per cycle; each pipeline stage holds under backpressure
// and empty stages close up, so input is taken while a result waits at the output.
// The depth is set by the gain multipliers, force mix, and the curve's square,
// quadratic, sum, scale and output stages. Synchronous reset empties the pipeline,
// zeroes the held forces and loads the register defaults.
module quad_x_motor_mixer_core #(
  parameter int FRAC_BITS = qxm_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // s_tdata: roll_torque[31:0], pitch_torque[63:32], yaw_torque[95:64],
  //          collective_offset[106:96], low_power[107], zero fill
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [qxm_pkg::S_DATA_W-1:0]       s_tdata,
  // m_tdata: motor1_compare[10:0], motor2_compare[21:11], motor3_compare[32:22],
  //          motor4_compare[43:33], zero fill
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [qxm_pkg::M_DATA_W-1:0]       m_tdata,
  input  logic                               cfg_we,
  input  logic [qxm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qxm_pkg::GAIN_W-1:0]         cfg_data
);
  import qxm_pkg::*;

  logic [MODE_W-1:0] mix_mode;
  logic [GAIN_W-1:0] arm_gain;
  logic [GAIN_W-1:0] hover_force;
  logic [GAIN_W-1:0] yaw_gain;

  logic [STAGES:1]   vld;
  logic [STAGES:1]   adv;

  logic signed [OFFSET_W-1:0] off_pipe [1:STAGES-1];
  logic                       low_pipe [1:STAGES-1];

  logic signed [TORQUE_W-1:0] roll_torque;
  logic signed [TORQUE_W-1:0] pitch_torque;
  logic signed [TORQUE_W-1:0] yaw_torque;
  logic signed [OFFSET_W-1:0] collective_offset;
  logic                       low_power;

  mix_ctl_t                   mix_ctl;
  curve_ctl_t                 curve_ctl;
  logic [3:0][FORCE_W-1:0]    motor_force;
  logic [3:0][COMPARE_W-1:0]  motor_compare;

  // Unpack the input transaction
  assign roll_torque       = $signed(s_tdata[31:0]);
  assign pitch_torque      = $signed(s_tdata[63:32]);
  assign yaw_torque        = $signed(s_tdata[95:64]);
  assign collective_offset = $signed(s_tdata[106:96]);
  assign low_power         = s_tdata[107];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mix_mode    <= MIX_MODE_RST;
      arm_gain    <= ARM_GAIN_RST;
      hover_force <= HOVER_FORCE_RST;
      yaw_gain    <= YAW_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIX_MODE:    mix_mode    <= cfg_data[MODE_W-1:0];
        REG_ARM_GAIN:    arm_gain    <= cfg_data;
        REG_HOVER_FORCE: hover_force <= cfg_data;
        REG_YAW_GAIN:    yaw_gain    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or the stage after it moves
  always_comb begin
    adv[STAGES] = ~vld[STAGES] | m_tready;
    for (int k = STAGES - 1; k >= 1; k--) begin
      adv[k] = ~vld[k] | adv[k+1];
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= s_tvalid;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Carry offset and low-power flag alongside the forces
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      off_pipe[1] <= collective_offset;
      low_pipe[1] <= low_power;
    end
    for (int k = 2; k <= STAGES - 1; k++) begin
      if (adv[k]) begin
        off_pipe[k] <= off_pipe[k-1];
        low_pipe[k] <= low_pipe[k-1];
      end
    end
  end

  assign mix_ctl.s1_en   = adv[1];
  assign mix_ctl.s2_en   = adv[2];
  assign mix_ctl.s2_take = adv[2] & vld[1];

  assign curve_ctl.s3_en = adv[3];
  assign curve_ctl.s4_en = adv[4];
  assign curve_ctl.s5_en = adv[5];
  assign curve_ctl.s6_en = adv[6];
  assign curve_ctl.s7_en = adv[7];

  qxm_mix #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mix (
    .clk          (clk),
    .rst          (rst),
    .ctl          (mix_ctl),
    .mix_mode     (mix_mode),
    .arm_gain     (arm_gain),
    .yaw_gain     (yaw_gain),
    .hover_force  (hover_force),
    .roll_torque  (roll_torque),
    .pitch_torque (pitch_torque),
    .yaw_torque   (yaw_torque),
    .motor_force  (motor_force)
  );

  // One curve pipeline per motor
  for (genvar g = 0; g < 4; g++) begin : g_motor
    qxm_curve #(
      .FRAC_BITS (FRAC_BITS)
    ) u_curve (
      .clk         (clk),
      .ctl         (curve_ctl),
      .motor_force (motor_force[g]),
      .offset      (off_pipe[STAGES-1]),
      .low_power   (low_pipe[STAGES-1]),
      .compare     (motor_compare[g])
    );
  end

  // Pack the output transaction
  assign s_tready = adv[1];
  assign m_tvalid = vld[STAGES];
  assign m_tdata  = {{(M_DATA_W - 4 * COMPARE_W){1'b0}}, motor_compare[3], motor_compare[2],
                     motor_compare[1], motor_compare[0]};

endmodule

// ----- rtl/qxm_checker.sv -----
// Port-level checks for the motor mixer core, attached by bind.
module qxm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  // A stalled output transaction holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output transaction changed while stalled");

  // Every motor compare stays inside 1000..1750
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[10:0] >= 11'd1000) && (m_tdata[10:0] <= 11'd1750) &&
                 (m_tdata[21:11] >= 11'd1000) && (m_tdata[21:11] <= 11'd1750) &&
                 (m_tdata[32:22] >= 11'd1000) && (m_tdata[32:22] <= 11'd1750) &&
                 (m_tdata[43:33] >= 11'd1000) && (m_tdata[43:33] <= 11'd1750))
    else $error("motor compare out of range");

  // An empty output stage lets the whole pipeline accept input
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output stage empty");

  // Reset empties the pipeline
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind quad_x_motor_mixer_core qxm_checker u_qxm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
